[design/fctc_pkg.sv]
// ----------------------------------------------------------------------------
// fctc_pkg: shared types and constants for the frame count / timecode converter
// Request and result structs, the sideband carried down the pipeline, and the
// fixed field widths and time-base constants.
// ----------------------------------------------------------------------------
package fctc_pkg;

  // field widths
  localparam int FC_W   = 23;  // frame count field
  localparam int HRS_W  = 12;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;
  localparam int FRM_W  = 7;
  localparam int FPS_W  = 7;

  // frames per minute and per hour at the highest rate (127*60, 127*3600)
  localparam int PER_MIN_W  = FPS_W + 6;
  localparam int PER_HOUR_W = FPS_W + 12;

  // seconds + 60*minutes + 3600*hours, all fields at full width
  localparam int TSUM_W = 24;
  // fps * seconds total, and that plus the frame
  localparam int PROD_W = TSUM_W + FPS_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam int SECS_PER_MIN  = 60;
  localparam int SECS_PER_HOUR = 3600;
  localparam int HOURS_MAX     = (1 << HRS_W) - 1;
  localparam logic [FPS_W-1:0] FPS_RESET = FPS_W'(25);

  // quotient bits resolved in each divider stage
  localparam int DIV_BITS_PER_STAGE = 4;

  typedef enum logic {
    CMD_SPLIT = 1'b0,
    CMD_BUILD = 1'b1
  } fctc_cmd_t;

  typedef struct packed {
    logic              command;
    logic [FC_W-1:0]   frame_count_in;
    logic [HRS_W-1:0]  hours_in;
    logic [MIN_W-1:0]  minutes_in;
    logic [SEC_W-1:0]  seconds_in;
    logic [FRM_W-1:0]  frames_in;
  } fctc_req_t;

  typedef struct packed {
    logic [FC_W-1:0]   frame_count_out;
    logic [HRS_W-1:0]  hours_out;
    logic [MIN_W-1:0]  minutes_out;
    logic [SEC_W-1:0]  seconds_out;
    logic [FRM_W-1:0]  frames_out;
    logic              overflow;
  } fctc_res_t;

  // travels alongside each request through the divider chain
  typedef struct packed {
    logic                 command;
    logic [FC_W-1:0]      count_echo;
    logic [HRS_W-1:0]     hours;
    logic [MIN_W-1:0]     minutes;
    logic [SEC_W-1:0]     seconds;
    logic [FRM_W-1:0]     frames;
    logic [FPS_W-1:0]     fps;
    logic [PER_MIN_W-1:0] per_min;
    logic [TSUM_W-1:0]    tsum;
    logic [HRS_W-1:0]     split_hours;
    logic                 split_hovf;
    logic [MIN_W-1:0]     split_minutes;
    logic [SEC_W-1:0]     split_seconds;
    logic [FRM_W-1:0]     split_frames;
  } fctc_side_t;

endpackage

[design/fctc_div_pipe.sv]
// ----------------------------------------------------------------------------
// fctc_div_pipe: pipelined restoring divider
// Resolves a few quotient bits per register stage, carrying the divisor and
// an opaque sideband with each request. Valid/stall flow control per stage.
// ----------------------------------------------------------------------------
module fctc_div_pipe #(
  parameter int DW  = 23,
  parameter int VW  = 7,
  parameter int PW  = 8,
  parameter int BPS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [DW-1:0] in_dividend,
  input  logic [VW-1:0] in_divisor,
  input  logic [PW-1:0] in_payload,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [DW-1:0] out_quotient,
  output logic [VW-1:0] out_remainder,
  output logic [PW-1:0] out_payload
);

  localparam int NST = (DW + BPS - 1) / BPS;

  logic          valid [NST];
  logic [DW-1:0] quo   [NST];
  logic [VW-1:0] rem   [NST];
  logic [VW-1:0] dvs   [NST];
  logic [PW-1:0] pay   [NST];
  logic          ready [NST+1];

  assign ready[NST] = !out_stall;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic          src_valid;
    logic [DW-1:0] src_q;
    logic [VW-1:0] src_r;
    logic [VW-1:0] src_v;
    logic [PW-1:0] src_p;
    logic [DW-1:0] nq;
    logic [VW-1:0] nr;

    if (k == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_q     = in_dividend;
      assign src_r     = '0;
      assign src_v     = in_divisor;
      assign src_p     = in_payload;
    end else begin : g_next
      assign src_valid = valid[k-1];
      assign src_q     = quo[k-1];
      assign src_r     = rem[k-1];
      assign src_v     = dvs[k-1];
      assign src_p     = pay[k-1];
    end

    assign ready[k] = !valid[k] || ready[k+1];

    // shift the next dividend bit into the remainder, subtract where it fits
    always_comb begin : step
      logic [VW:0] trial;
      nq    = src_q;
      nr    = src_r;
      trial = '0;
      for (int j = 0; j < BPS; j++) begin
        if (k * BPS + j < DW) begin
          trial = {nr, nq[DW-1]};
          nq    = {nq[DW-2:0], 1'b0};
          if (trial >= {1'b0, src_v}) begin
            nr    = VW'(trial - {1'b0, src_v});
            nq[0] = 1'b1;
          end else begin
            nr = trial[VW-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (ready[k]) begin
        valid[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (ready[k] && src_valid) begin
        quo[k] <= nq;
        rem[k] <= nr;
        dvs[k] <= src_v;
        pay[k] <= src_p;
      end
    end
  end

  assign in_stall      = !ready[0];
  assign out_valid     = valid[NST-1];
  assign out_quotient  = quo[NST-1];
  assign out_remainder = rem[NST-1];
  assign out_payload   = pay[NST-1];

endmodule

[design/fctc_tail.sv]
// ----------------------------------------------------------------------------
// fctc_tail: rate multiply, saturation and result register
// Stage A multiplies the seconds total by the frame rate; stage B adds the
// frame, saturates and selects the result by command, zeroing a split at rate 0.
// ----------------------------------------------------------------------------
module fctc_tail #(
  parameter int CW = 23
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  fctc_pkg::fctc_side_t         side,
  output logic                         out_valid,
  input  logic                         out_stall,
  output fctc_pkg::fctc_res_t          out_data
);

  localparam logic [fctc_pkg::SUM_W:0] COUNT_MAX =
    {{(fctc_pkg::SUM_W + 1 - CW){1'b0}}, {CW{1'b1}}};

  // stage A
  logic                             valid_a;
  fctc_pkg::fctc_side_t             side_a;
  logic [fctc_pkg::PROD_W-1:0]      prod_a;
  logic                             ready_a;
  logic                             ready_b;

  logic [fctc_pkg::SUM_W-1:0]       sum;
  logic                             sat;
  fctc_pkg::fctc_res_t              res_next;

  assign ready_b  = !out_valid || !out_stall;
  assign ready_a  = !valid_a || ready_b;
  assign in_stall = !ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (ready_a) begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      side_a <= side;
      prod_a <= fctc_pkg::PROD_W'(side.fps) * fctc_pkg::PROD_W'(side.tsum);
    end
  end

  // stage B: add the frame, saturate, pick the direction
  assign sum = fctc_pkg::SUM_W'(prod_a) + fctc_pkg::SUM_W'(side_a.frames);
  assign sat = {1'b0, sum} > COUNT_MAX;

  always_comb begin
    if (side_a.command == fctc_pkg::CMD_BUILD) begin
      res_next.frame_count_out = sat ? COUNT_MAX[fctc_pkg::FC_W-1:0]
                                     : sum[fctc_pkg::FC_W-1:0];
      res_next.hours_out       = side_a.hours;
      res_next.minutes_out     = side_a.minutes;
      res_next.seconds_out     = side_a.seconds;
      res_next.frames_out      = side_a.frames;
      res_next.overflow        = sat;
    end else if (side_a.fps == '0) begin
      res_next.frame_count_out = side_a.count_echo;
      res_next.hours_out       = '0;
      res_next.minutes_out     = '0;
      res_next.seconds_out     = '0;
      res_next.frames_out      = '0;
      res_next.overflow        = 1'b0;
    end else begin
      res_next.frame_count_out = side_a.count_echo;
      res_next.hours_out       = side_a.split_hours;
      res_next.minutes_out     = side_a.split_minutes;
      res_next.seconds_out     = side_a.split_seconds;
      res_next.frames_out      = side_a.split_frames;
      res_next.overflow        = side_a.split_hovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_b) begin
      out_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && valid_a) begin
      out_data <= res_next;
    end
  end

endmodule

[design/frame_count_timecode_converter_core.sv]
// Stages from request to result: one entry stage, three divider chains of
// ceil(COUNT_WIDTH/4), 5 and 4 stages, and two tail stages.
// Throughput: one request per cycle unless stalled; every stage holds a valid
// bit and loads whenever it is empty or its successor moves, so bubbles close
// up on stall.
// Reset (synchronous, rst high): clear all stage valid bits, frame rate to 25.
// ----------------------------------------------------------------------------
// frame_count_timecode_converter_core: non-drop-frame timecode converter
// Splits a frame count into hours, minutes, seconds and frames, or builds a
// frame count from a timecode, at a configurable integer frame rate.
// ----------------------------------------------------------------------------
module frame_count_timecode_converter_core #(
  parameter int COUNT_WIDTH = 23
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [fctc_pkg::FPS_W-1:0]  cfg_write_data,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  fctc_pkg::fctc_req_t         req_data,
  output logic                        res_valid,
  input  logic                        res_stall,
  output fctc_pkg::fctc_res_t         res_data
);

  localparam int CW = COUNT_WIDTH;

  // Splitting works long-hand: hours = count / (fps*3600), minutes from that
  // remainder by fps*60, then seconds and the frame from the last remainder
  // by fps. Every divisor follows the frame rate, so each divide runs in its
  // own pipelined restoring divider. Building folds the timecode into a
  // seconds total at entry, multiplies by the rate at the tail and adds the
  // frame there.

  // frame rate register
  logic [fctc_pkg::FPS_W-1:0] fps;

  always_ff @(posedge clk) begin
    if (rst) begin
      fps <= fctc_pkg::FPS_RESET;
    end else if (cfg_write_en) begin
      fps <= cfg_write_data;
    end
  end

  // entry stage: mask the count, form the seconds total, latch the rate and
  // the frames per minute and per hour
  logic [CW-1:0]                   count_in;
  logic [fctc_pkg::FC_W-1:0]       count_echo;
  logic [fctc_pkg::TSUM_W-1:0]     tsum_next;
  logic [fctc_pkg::PER_HOUR_W-1:0] per_hour_next;
  logic [fctc_pkg::PER_MIN_W-1:0]  per_min_next;

  if (CW >= fctc_pkg::FC_W) begin : g_wide
    assign count_in   = CW'(req_data.frame_count_in);
    assign count_echo = req_data.frame_count_in;
  end else begin : g_narrow
    assign count_in   = req_data.frame_count_in[CW-1:0];
    assign count_echo = fctc_pkg::FC_W'(req_data.frame_count_in[CW-1:0]);
  end

  assign tsum_next =
      fctc_pkg::TSUM_W'(req_data.seconds_in)
    + fctc_pkg::TSUM_W'(req_data.minutes_in) * fctc_pkg::TSUM_W'(fctc_pkg::SECS_PER_MIN)
    + fctc_pkg::TSUM_W'(req_data.hours_in) * fctc_pkg::TSUM_W'(fctc_pkg::SECS_PER_HOUR);

  assign per_hour_next = fctc_pkg::PER_HOUR_W'(fps)
                       * fctc_pkg::PER_HOUR_W'(fctc_pkg::SECS_PER_HOUR);
  assign per_min_next  = fctc_pkg::PER_MIN_W'(fps)
                       * fctc_pkg::PER_MIN_W'(fctc_pkg::SECS_PER_MIN);

  logic                            s0_valid;
  logic [CW-1:0]                   s0_count;
  logic [fctc_pkg::PER_HOUR_W-1:0] s0_per_hour;
  fctc_pkg::fctc_side_t            s0_side;
  logic                            s0_ready;
  logic                            d1_stall;

  assign s0_ready  = !s0_valid || !d1_stall;
  assign req_stall = !s0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && req_valid) begin
      s0_count              <= count_in;
      s0_per_hour           <= per_hour_next;
      s0_side.command       <= req_data.command;
      s0_side.count_echo    <= count_echo;
      s0_side.hours         <= req_data.hours_in;
      s0_side.minutes       <= req_data.minutes_in;
      s0_side.seconds       <= req_data.seconds_in;
      s0_side.frames        <= req_data.frames_in;
      s0_side.fps           <= fps;
      s0_side.per_min       <= per_min_next;
      s0_side.tsum          <= tsum_next;
      s0_side.split_hours   <= '0;
      s0_side.split_hovf    <= 1'b0;
      s0_side.split_minutes <= '0;
      s0_side.split_seconds <= '0;
      s0_side.split_frames  <= '0;
    end
  end

  // count / frames per hour: hours as quotient
  logic                            d1_valid;
  logic                            d2_stall;
  logic [CW-1:0]                   d1_quo;
  logic [fctc_pkg::PER_HOUR_W-1:0] d1_rem;
  fctc_pkg::fctc_side_t            d1_side;
  logic                            d1_hovf;
  fctc_pkg::fctc_side_t            d2_side_in;

  fctc_div_pipe #(
    .DW  (CW),
    .VW  (fctc_pkg::PER_HOUR_W),
    .PW  ($bits(fctc_pkg::fctc_side_t)),
    .BPS (fctc_pkg::DIV_BITS_PER_STAGE)
  ) u_div_hour (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s0_valid),
    .in_stall      (d1_stall),
    .in_dividend   (s0_count),
    .in_divisor    (s0_per_hour),
    .in_payload    (s0_side),
    .out_valid     (d1_valid),
    .out_stall     (d2_stall),
    .out_quotient  (d1_quo),
    .out_remainder (d1_rem),
    .out_payload   (d1_side)
  );

  // clamp hours that do not fit the field and flag it
  assign d1_hovf = |d1_quo[CW-1:fctc_pkg::HRS_W];

  always_comb begin
    d2_side_in             = d1_side;
    d2_side_in.split_hovf  = d1_hovf;
    d2_side_in.split_hours = d1_hovf ? fctc_pkg::HRS_W'(fctc_pkg::HOURS_MAX)
                                     : d1_quo[fctc_pkg::HRS_W-1:0];
  end

  // remainder / frames per minute: minutes as quotient
  logic                            d2_valid;
  logic                            d3_stall;
  logic [fctc_pkg::PER_HOUR_W-1:0] d2_quo;
  logic [fctc_pkg::PER_MIN_W-1:0]  d2_rem;
  fctc_pkg::fctc_side_t            d2_side;
  fctc_pkg::fctc_side_t            d3_side_in;

  fctc_div_pipe #(
    .DW  (fctc_pkg::PER_HOUR_W),
    .VW  (fctc_pkg::PER_MIN_W),
    .PW  ($bits(fctc_pkg::fctc_side_t)),
    .BPS (fctc_pkg::DIV_BITS_PER_STAGE)
  ) u_div_min (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (d1_valid),
    .in_stall      (d2_stall),
    .in_dividend   (d1_rem),
    .in_divisor    (d1_side.per_min),
    .in_payload    (d2_side_in),
    .out_valid     (d2_valid),
    .out_stall     (d3_stall),
    .out_quotient  (d2_quo),
    .out_remainder (d2_rem),
    .out_payload   (d2_side)
  );

  // the remainder is below an hour, so the minutes fit the field
  always_comb begin
    d3_side_in               = d2_side;
    d3_side_in.split_minutes = d2_quo[fctc_pkg::MIN_W-1:0];
  end

  // remainder / fps: seconds as quotient, frame within the second as remainder
  logic                           d3_valid;
  logic                           tail_stall;
  logic [fctc_pkg::PER_MIN_W-1:0] d3_quo;
  logic [fctc_pkg::FPS_W-1:0]     d3_rem;
  fctc_pkg::fctc_side_t           d3_side;
  fctc_pkg::fctc_side_t           d4_side_in;

  fctc_div_pipe #(
    .DW  (fctc_pkg::PER_MIN_W),
    .VW  (fctc_pkg::FPS_W),
    .PW  ($bits(fctc_pkg::fctc_side_t)),
    .BPS (fctc_pkg::DIV_BITS_PER_STAGE)
  ) u_div_sec (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (d2_valid),
    .in_stall      (d3_stall),
    .in_dividend   (d2_rem),
    .in_divisor    (d2_side.fps),
    .in_payload    (d3_side_in),
    .out_valid     (d3_valid),
    .out_stall     (tail_stall),
    .out_quotient  (d3_quo),
    .out_remainder (d3_rem),
    .out_payload   (d3_side)
  );

  always_comb begin
    d4_side_in               = d3_side;
    d4_side_in.split_seconds = d3_quo[fctc_pkg::SEC_W-1:0];
    d4_side_in.split_frames  = d3_rem;
  end

  // rate multiply, saturation and the result register
  fctc_tail #(
    .CW (CW)
  ) u_tail (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d3_valid),
    .in_stall  (tail_stall),
    .side      (d4_side_in),
    .out_valid (res_valid),
    .out_stall (res_stall),
    .out_data  (res_data)
  );

endmodule
